FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file; clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fbra_pkg.sv
// Types and constants shared by the free bit run allocator modules.
package fbra_pkg;

	localparam int BYTE_BITS = 8;
	localparam int SPAN_BYTES = 128;
	localparam logic [7:0] USED_BYTES_RST = 8'd128;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TEST  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  bit_index;
		logic        bit_value;
		logic [10:0] run_length;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] start_index;
		logic       bit_state;
		logic       out_of_range;
	} result_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rd_idx;
		logic scan_run;
		logic write;
		logic capture;
		logic clear;
		logic push;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic oor;
		logic scan_done;
	} stat_t;

endpackage

FILE: hdl/fbra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	clk,
	we,
	waddr,
	wdata,
	re,
	raddr,
	rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  logic             clk;
	input  logic             we;
	input  logic [AW-1:0]    waddr;
	input  logic [WIDTH-1:0] wdata;
	input  logic             re;
	input  logic [AW-1:0]    raddr;
	output logic [WIDTH-1:0] rdata;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/fbra_ctrl.sv
// Controller state machine of the free bit run allocator.
module fbra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	output fbra_pkg::cmd_t  cmd,
	input  fbra_pkg::stat_t stat
);
	import fbra_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_MODIFY,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   result_valid_q;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = item_valid;
				if (item_valid) begin
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.start = 1'b1;
				unique case (stat.op) inside
					OP_SCAN: begin
						state_nxt = ST_SCAN;
					end
					OP_WRITE, OP_TEST: begin
						cmd.rd_idx = !stat.oor;
						state_nxt = stat.oor ? ST_DONE : ST_MODIFY;
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_nxt = ST_DONE;
					end
					default: begin
						state_nxt = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_MODIFY: begin
				cmd.write = (stat.op == OP_WRITE);
				cmd.capture = (stat.op == OP_TEST);
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				cmd.push = !result_valid_q || result_ready;
				if (cmd.push) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.push) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/fbra_dp.sv
// Datapath of the free bit run allocator: bitmap memory, run counter and result register.
module fbra_dp #(
	parameter int DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  fbra_pkg::item_t   item,
	input  fbra_pkg::cmd_t    cmd,
	output fbra_pkg::stat_t   stat,
	output fbra_pkg::result_t result
);
	import fbra_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [7:0] DEPTH_BYTES = 8'(DEPTH);

	item_t       item_q;
	result_t     result_q;
	logic [7:0]  used_q;
	logic [7:0]  addr_q;
	logic [6:0]  byte_s1;
	logic        pend_s1;
	logic        vld_s1;
	logic [10:0] cnt_q;
	logic        found_q;
	logic [9:0]  start_q;
	logic        bit_q;
	logic [DEPTH-1:0] valid_q;

	logic [7:0]    lim_bytes;
	logic [6:0]    byte_sel;
	logic [10:0]   len_eff;
	logic          more;
	logic          issue;
	logic          rd_en;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    old_byte;
	logic [7:0]    mask;
	logic [7:0]    new_byte;
	logic          oor;
	op_t           op;
	logic [10:0]   run_cnt;
	logic          run_hit;
	logic [10:0]   run_start;

	assign op        = op_t'(item_q.operation);
	assign lim_bytes = (used_q > DEPTH_BYTES) ? DEPTH_BYTES : used_q;
	assign byte_sel  = item_q.bit_index[9:3];
	assign len_eff   = (item_q.run_length == 11'd0) ? 11'd1 : item_q.run_length;
	assign more      = (addr_q < lim_bytes);
	assign issue     = cmd.scan_run && !found_q && more;
	assign rd_en     = issue || cmd.rd_idx;
	assign raddr     = cmd.rd_idx ? byte_sel[AW-1:0] : addr_q[AW-1:0];
	assign old_byte  = vld_s1 ? rdata : 8'd0;
	assign mask      = 8'd1 << item_q.bit_index[2:0];
	assign new_byte  = item_q.bit_value ? (old_byte | mask) : (old_byte & ~mask);
	assign oor       = ((op == OP_WRITE) || (op == OP_TEST)) && ({1'b0, byte_sel} >= lim_bytes);

	assign stat.op        = op;
	assign stat.oor       = oor;
	assign stat.scan_done = found_q || (!more && !pend_s1);
	assign result         = result_q;

	// Walk the eight bits of one byte, lowest first, extending the current free run.
	always_comb begin
		run_cnt = cnt_q;
		run_hit = 1'b0;
		run_start = '0;
		for (int i = 0; i < BYTE_BITS; i++) begin
			if (!run_hit) begin
				if (old_byte[i]) begin
					run_cnt = '0;
				end else begin
					run_cnt = run_cnt + 11'd1;
				end
				if (run_cnt == len_eff) begin
					run_hit = 1'b1;
					run_start = {1'b0, byte_s1, 3'(i)} + 11'd1 - len_eff;
				end
			end
		end
	end

	fbra_ram #(
		.WIDTH(BYTE_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(byte_sel[AW-1:0]),
		.wdata(new_byte),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_BYTES_RST;
			addr_q <= '0;
			pend_s1 <= 1'b0;
			cnt_q <= '0;
			found_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				used_q <= cfg_wdata;
			end
			if (cmd.start) begin
				addr_q <= '0;
				pend_s1 <= 1'b0;
				cnt_q <= '0;
				found_q <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + 8'd1;
				end
				if (pend_s1 && !found_q) begin
					cnt_q <= run_cnt;
					found_q <= run_hit;
				end
			end
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.write) begin
				valid_q[byte_sel[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (rd_en) begin
			vld_s1 <= valid_q[raddr];
			byte_s1 <= addr_q[6:0];
		end
		if (cmd.start) begin
			start_q <= '0;
			bit_q <= 1'b0;
		end else begin
			if (pend_s1 && !found_q && run_hit) begin
				start_q <= run_start[9:0];
			end
			if (cmd.capture) begin
				bit_q <= old_byte[item_q.bit_index[2:0]];
			end
		end
		if (cmd.push) begin
			result_q <= '{
				found: found_q,
				start_index: start_q,
				bit_state: bit_q,
				out_of_range: oor
			};
		end
	end

endmodule

FILE: hdl/free_bit_run_allocator.sv
// Top level of the free bit run allocator: first-fit search for free bit runs in a bitmap.
// Write and test go through dispatch, modify and done; out of range and clear-all skip modify.
// Scan reads the bitmap one byte per cycle through the memory read port, up to the bytes
// in use, and stops early once a free run of the requested length is found.
// One item is in work at a time.
// Reset clears the byte valid flags (bitmap reads as all zeros) and sets 128 bytes in use.
`include "assert_macros.svh"

module free_bit_run_allocator #(
	parameter int MAX_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              item_valid,
	output logic              item_ready,
	input  fbra_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output fbra_pkg::result_t result
);
	import fbra_pkg::*;

	localparam int EFF_BYTES = (MAX_BYTES < SPAN_BYTES) ? MAX_BYTES : SPAN_BYTES;

	cmd_t  cmd;
	stat_t stat;

	fbra_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	fbra_dp #(
		.DEPTH(EFF_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	`ASSERT_NEXT(a_start_after_transfer, item_valid && item_ready, cmd.start, "no dispatch after transfer")
	`ASSERT_IMPLIES(a_push_slot_free, cmd.push, !result_valid || result_ready, "result overwritten")
	`ASSERT_IMPLIES(a_write_in_range, cmd.write, !stat.oor && !cmd.clear, "write out of range")
	`ASSERT_IMPLIES(a_valid_from_push, $rose(result_valid), $past(cmd.push), "result without push")

endmodule

FILE: dv/free_bit_run_allocator_checker.sv
// Checker for the free bit run allocator: mirrors the bitmap and compares every result.
`timescale 1ns / 100ps

module free_bit_run_allocator_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              item_valid,
	input  logic              item_ready,
	input  fbra_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  fbra_pkg::result_t result,
	output int                mismatches,
	output int                outstanding
);
	import fbra_pkg::*;

	logic [7:0] bitmap [SPAN_BYTES];
	logic [7:0] used_bytes;
	result_t    expected_results [$];
	result_t    oldest;

	function automatic result_t apply_bitmap_op(item_t it);
		result_t r;
		int      lim;
		int      pos;
		int      run;
		int      want;
		int      idx;
		r = '0;
		lim = ((used_bytes > SPAN_BYTES) ? SPAN_BYTES : int'(used_bytes)) * BYTE_BITS;
		idx = it.bit_index;
		case (op_t'(it.operation)) inside
			OP_SCAN: begin
				want = (it.run_length == 0) ? 1 : int'(it.run_length);
				run = 0;
				pos = 0;
				while (pos < lim && !r.found) begin
					if (pos % 8 == 0 && bitmap[pos / 8] == 8'hff) begin
						run = 0;
						pos += 8;
					end else begin
						if (bitmap[pos / 8][pos % 8])
							run = 0;
						else
							run++;
						if (run == want) begin
							r.found = 1'b1;
							r.start_index = 10'(pos + 1 - want);
						end
						pos++;
					end
				end
			end
			OP_WRITE, OP_TEST: begin
				if (idx >= lim)
					r.out_of_range = 1'b1;
				else if (op_t'(it.operation) == OP_WRITE)
					bitmap[idx / 8][idx % 8] = it.bit_value;
				else
					r.bit_state = bitmap[idx / 8][idx % 8];
			end
			default: begin
				foreach (bitmap[i])
					bitmap[i] = 8'h00;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (bitmap[i])
				bitmap[i] = 8'h00;
			used_bytes = USED_BYTES_RST;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we)
				used_bytes = cfg_wdata;
			if (item_valid && item_ready)
				expected_results.push_back(apply_bitmap_op(item));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					compare_field("found", oldest.found, result.found);
					compare_field("start_index", oldest.start_index, result.start_index);
					compare_field("bit_state", oldest.bit_state, result.bit_state);
					compare_field("out_of_range", oldest.out_of_range, result.out_of_range);
				end
			end
		end
		outstanding = expected_results.size();
	end

endmodule

FILE: dv/tb_free_bit_run_allocator.sv
// Testbench top for the free bit run allocator: directed and random stimulus with a verdict.
`timescale 1ns / 100ps

module tb_free_bit_run_allocator;
	import fbra_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic [7:0] cfg_wdata;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	int      mismatches;
	int      outstanding;
	int      send_idle;
	int      recv_idle;
	int      used_now;

	free_bit_run_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	free_bit_run_allocator_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int bit_limit();
		return ((used_now > SPAN_BYTES) ? SPAN_BYTES : used_now) * BYTE_BITS;
	endfunction

	task automatic put(item_t x);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	task automatic issue(op_t op, int idx, bit val, int len);
		item_t x;
		x.operation = op;
		x.bit_index = 10'(idx);
		x.bit_value = val;
		x.run_length = 11'(len);
		put(x);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_used(int value);
		cfg_we <= 1'b1;
		cfg_wdata <= 8'(value);
		used_now = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] used_plan [12];
		item_t      x;
		int         count;
		int         lim;
		int         pick;
		int         base;
		int         span;
		int         hole;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		item_valid = 1'b0;
		item = '0;
		send_idle = 33;
		recv_idle = 86;
		used_now = USED_BYTES_RST;
		used_plan = '{8'd1, 8'd128, 8'd16, 8'd3, 8'd255, 8'd64,
			8'd2, 8'd130, 8'd200, 8'd0, 8'd127, 8'd8};
		used_plan[9] = 8'($urandom_range(1, 255));
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(OP_SCAN, 0, 1'b1, 0);
		issue(OP_SCAN, 1023, 1'b0, 1024);
		issue(OP_SCAN, 0, 1'b0, 1025);
		issue(OP_SCAN, 0, 1'b1, 2047);
		issue(OP_WRITE, 0, 1'b1, 0);
		issue(OP_WRITE, 1023, 1'b1, 2047);
		issue(OP_TEST, 0, 1'b0, 0);
		issue(OP_TEST, 1023, 1'b1, 0);
		issue(OP_SCAN, 0, 1'b0, 1);
		issue(OP_SCAN, 0, 1'b0, 1022);
		issue(OP_SCAN, 0, 1'b0, 1023);
		issue(OP_WRITE, 0, 1'b0, 0);
		for (int b = 8; b < 16; b++)
			issue(OP_WRITE, b, 1'b1, 0);
		issue(OP_SCAN, 0, 1'b0, 8);
		issue(OP_SCAN, 0, 1'b0, 9);
		issue(OP_CLEAR, 1023, 1'b1, 2047);
		issue(OP_TEST, 1023, 1'b0, 0);
		drain();

		set_used(0);
		issue(OP_SCAN, 0, 1'b0, 1);
		issue(OP_WRITE, 5, 1'b1, 0);
		issue(OP_TEST, 0, 1'b0, 0);
		drain();

		set_used(255);
		issue(OP_WRITE, 1023, 1'b1, 0);
		issue(OP_WRITE, 900, 1'b1, 0);
		issue(OP_TEST, 1023, 1'b0, 0);
		issue(OP_SCAN, 0, 1'b0, 1024);
		drain();

		set_used(1);
		issue(OP_TEST, 900, 1'b0, 0);
		issue(OP_WRITE, 8, 1'b1, 0);
		issue(OP_SCAN, 0, 1'b0, 8);
		issue(OP_SCAN, 0, 1'b0, 9);
		issue(OP_CLEAR, 0, 1'b0, 0);
		drain();

		set_used(128);
		issue(OP_TEST, 900, 1'b0, 0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			send_idle = (ph < 4) ? 33 : ((ph < 8) ? 86 : 0);
			recv_idle = (ph < 4) ? 86 : ((ph < 8) ? 33 : 0);
			set_used(used_plan[ph]);
			lim = bit_limit();
			count = 0;
			while (count < 134) begin
				pick = $urandom_range(99);
				if (pick < 8 && lim > 0) begin
					base = $urandom_range(lim / 8 - 1) * 8;
					hole = $urandom_range(15);
					for (int b = 0; b < 8; b++)
						issue(OP_WRITE, base + b, (b != hole), $urandom_range(2047));
					count += 8;
				end else if (pick < 14 && lim > 0) begin
					base = $urandom_range(lim - 1);
					span = $urandom_range(1, 12);
					for (int b = 0; b < span; b++)
						issue(OP_WRITE, (base + b) % 1024, 1'b0, $urandom_range(2047));
					count += span;
				end else begin
					x = item_t'(24'($urandom));
					pick = $urandom_range(99);
					x.operation = (pick < 40) ? OP_WRITE : ((pick < 60) ? OP_TEST :
						((pick < 97) ? OP_SCAN : OP_CLEAR));
					if (lim > 0 && $urandom_range(99) < 90)
						x.bit_index = 10'($urandom_range(lim - 1));
					if (x.operation == OP_WRITE)
						x.bit_value = ($urandom_range(99) < 75);
					pick = $urandom_range(99);
					if (pick < 5)
						x.run_length = 11'd0;
					else if (pick < 70)
						x.run_length = 11'($urandom_range(1, 12));
					else if (pick < 90)
						x.run_length = 11'($urandom_range(13, 100));
					put(x);
					count++;
				end
			end
			drain();
		end

		repeat (150) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/fbra_pkg.sv
hdl/fbra_ram.sv
hdl/fbra_ctrl.sv
hdl/fbra_dp.sv
hdl/free_bit_run_allocator.sv
dv/free_bit_run_allocator_checker.sv
dv/tb_free_bit_run_allocator.sv
